// File: design/cct_pkg.sv
// shared types, constants and calendar helper functions for the calendar clock core
package cct_pkg;

  // action codes
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  // rollover limits
  localparam logic [5:0] SEC_PER_MIN     = 6'd60;
  localparam logic [5:0] MIN_PER_HOUR    = 6'd60;
  localparam logic [4:0] HOURS_PER_DAY   = 5'd24;
  localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
  localparam logic [3:0] MONTH_FEB       = 4'd2;

  // accepted load year range
  localparam logic [13:0] YEAR_MIN = 14'd1901;
  localparam logic [13:0] YEAR_MAX = 14'd9999;

  // reset date
  localparam logic [4:0]  RST_DAY   = 5'd1;
  localparam logic [3:0]  RST_MONTH = 4'd1;
  localparam logic [13:0] RST_YEAR  = 14'd1901;

  // y / 25 by reciprocal: q = (y * RECIP_25) >> RECIP_SHIFT, exact for 14-bit y
  localparam logic [14:0] RECIP_25    = 15'd20972;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [4:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } cct_time_t;

  typedef struct packed {
    logic        action;
    logic [4:0]  set_hours;
    logic [5:0]  set_minutes;
    logic [5:0]  set_seconds;
    logic [4:0]  set_day;
    logic [3:0]  set_month;
    logic [13:0] set_year;
  } cct_item_t;

  typedef struct packed {
    logic day_rolled;
    logic load_rejected;
  } cct_flags_t;

  // gregorian leap test; divisibility by 25 via reciprocal multiply and check
  function automatic logic leap_year(input logic [13:0] y);
    logic [28:0] prod;
    logic [9:0]  q;
    logic [13:0] back;
    logic        div25;
    prod  = 29'(y) * 29'(RECIP_25);
    q     = prod[28:RECIP_SHIFT];
    back  = {q, 4'b0000} + 14'({q, 3'b000}) + 14'(q);
    div25 = (back == y);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  // month length, 31 for a month code outside 1..12
  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m < 4'd1 || m > MONTHS_PER_YEAR) begin
      len = 5'd31;
    end else begin
      len = MONTH_DAYS[m - 4'd1];
      if (m == MONTH_FEB && leap) begin
        len = len + 5'd1;
      end
    end
    return len;
  endfunction

endpackage

// File: design/cct_step.sv
// next-state logic for one tick or load transaction
module cct_step
  import cct_pkg::*;
(
  input  cct_time_t  cur,
  input  cct_item_t  item,
  output cct_time_t  nxt,
  output cct_flags_t flags
);

  logic       cur_leap;
  logic       set_leap;
  logic [6:0] sec_inc;
  logic [6:0] min_inc;
  logic [5:0] hour_inc;
  logic [5:0] day_inc;
  logic [4:0] month_inc;
  logic       carry_min;
  logic       carry_hour;
  logic       rolled;
  logic       load_ok;

  assign cur_leap = leap_year(cur.year);
  assign set_leap = leap_year(item.set_year);

  always_comb begin
    sec_inc    = {1'b0, cur.seconds} + 7'd1;
    min_inc    = {1'b0, cur.minutes} + 7'd1;
    hour_inc   = {1'b0, cur.hours} + 6'd1;
    day_inc    = {1'b0, cur.day} + 6'd1;
    month_inc  = {1'b0, cur.month} + 5'd1;
    carry_min  = (sec_inc >= {1'b0, SEC_PER_MIN});
    carry_hour = carry_min && (min_inc >= {1'b0, MIN_PER_HOUR});
    rolled     = carry_hour && (hour_inc >= {1'b0, HOURS_PER_DAY});

    load_ok = (item.set_year inside {[YEAR_MIN:YEAR_MAX]})
           && (item.set_month inside {[4'd1:MONTHS_PER_YEAR]})
           && (item.set_day != 5'd0)
           && (item.set_day <= days_in(item.set_month, set_leap))
           && (item.set_hours < HOURS_PER_DAY)
           && (item.set_minutes < MIN_PER_HOUR)
           && (item.set_seconds < SEC_PER_MIN);

    nxt   = cur;
    flags = '0;

    if (item.action == ACT_TICK) begin
      nxt.seconds = carry_min ? 6'd0 : sec_inc[5:0];
      if (carry_min) begin
        nxt.minutes = carry_hour ? 6'd0 : min_inc[5:0];
      end
      if (carry_hour) begin
        nxt.hours = rolled ? 5'd0 : hour_inc[4:0];
      end
      if (rolled) begin
        flags.day_rolled = 1'b1;
        if (day_inc > {1'b0, days_in(cur.month, cur_leap)}) begin
          nxt.day = 5'd1;
          if (month_inc > {1'b0, MONTHS_PER_YEAR}) begin
            nxt.month = 4'd1;
            nxt.year  = cur.year + 14'd1;
          end else begin
            nxt.month = month_inc[3:0];
          end
        end else begin
          nxt.day = day_inc[4:0];
        end
      end
    end else begin
      if (load_ok) begin
        nxt.hours   = item.set_hours;
        nxt.minutes = item.set_minutes;
        nxt.seconds = item.set_seconds;
        nxt.day     = item.set_day;
        nxt.month   = item.set_month;
        nxt.year    = item.set_year;
      end else begin
        flags.load_rejected = 1'b1;
      end
    end
  end

endmodule

// File: design/calendar_clock_tick_core.sv
// top level of the calendar clock core: input register, time state and result handshake
//
//   channel | signals                                   | role
//   --------+-------------------------------------------+------------------------------
//   in      | in_valid, in_ready, action, set_*         | tick or load transaction
//   out     | out_valid, out_ready, *_now, day_rolled,  | date and time after each
//           | load_rejected                             | transaction, plus status flags
//
// one transaction per cycle sustained while the result is not stalled; a transaction
// passes through the input register, then the step logic into the time registers
// the time registers double as the result register, so they only change when the
// result slot is empty or being taken in the same cycle
// reset (synchronous) returns to 00:00:00 on day 1, month 1, year 1901 with both
// channels empty
// an output stall backs up through the input register; in_ready drops only when
// the input register is full and the held result is not being taken
module calendar_clock_tick_core
  import cct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [4:0]  set_hours,
  input  logic [5:0]  set_minutes,
  input  logic [5:0]  set_seconds,
  input  logic [4:0]  set_day,
  input  logic [3:0]  set_month,
  input  logic [13:0] set_year,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  hours_now,
  output logic [5:0]  minutes_now,
  output logic [5:0]  seconds_now,
  output logic [4:0]  day_now,
  output logic [3:0]  month_now,
  output logic [13:0] year_now,
  output logic        day_rolled,
  output logic        load_rejected
);

  // input register
  logic       in_full;
  cct_item_t  in_q;

  // time state, which is also the visible result
  cct_time_t  cur;
  cct_time_t  cur_next;
  cct_flags_t flags;
  cct_flags_t flags_next;

  logic       advance;
  logic       in_take;

  // the held transaction moves on when the result slot is free or draining
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;
  assign in_take  = in_valid && in_ready;

  cct_step u_step (
    .cur   (cur),
    .item  (in_q),
    .nxt   (cur_next),
    .flags (flags_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q <= '{action:      action,
                set_hours:   set_hours,
                set_minutes: set_minutes,
                set_seconds: set_seconds,
                set_day:     set_day,
                set_month:   set_month,
                set_year:    set_year};
    end
  end

  // time state and status flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= '{hours: 5'd0, minutes: 6'd0, seconds: 6'd0,
                     day: RST_DAY, month: RST_MONTH, year: RST_YEAR};
      flags     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        cur   <= cur_next;
        flags <= flags_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign hours_now     = cur.hours;
  assign minutes_now   = cur.minutes;
  assign seconds_now   = cur.seconds;
  assign day_now       = cur.day;
  assign month_now     = cur.month;
  assign year_now      = cur.year;
  assign day_rolled    = flags.day_rolled;
  assign load_rejected = flags.load_rejected;

`ifndef NO_ASSERTIONS
  // a transaction is either a tick or a load, never flagged as both
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(day_rolled && load_rejected))
    else $error("day_rolled and load_rejected both set");

  // a rejected load leaves the date and time untouched
  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    (advance && flags_next.load_rejected) |=> $stable(cur))
    else $error("rejected load changed the time state");

  // time counters stay in range
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    (seconds_now < SEC_PER_MIN) && (minutes_now < MIN_PER_HOUR)
    && (hours_now < HOURS_PER_DAY) && (day_now != 5'd0)
    && (month_now != 4'd0) && (month_now <= MONTHS_PER_YEAR))
    else $error("time counter out of range");

  // input back-pressure only comes from a full input register and a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (in_full && out_valid && !out_ready))
    else $error("in_ready low without an output stall");
`endif

endmodule
